// ===== hw/rtl/iterative_stiffness_reduction_step_top_defines.svh =====
// Assertion macros for the stiffness reduction step block.
// Used by modules that carry concurrent assertions; expects clock and reset in scope.
`ifndef ITERATIVE_STIFFNESS_REDUCTION_STEP_TOP_DEFINES_SVH
`define ITERATIVE_STIFFNESS_REDUCTION_STEP_TOP_DEFINES_SVH

// same-cycle implication
`define ISRS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ISRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/isrs_pkg.sv =====
// Shared types and constants of the stiffness reduction step block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package isrs_pkg;
   localparam int FRAC_BITS   = 16;
   localparam int TOTAL_WIDTH = 32;
   localparam int QBITS       = TOTAL_WIDTH - 1 + FRAC_BITS;
   localparam int NUM_W       = 63;
   localparam int DEN_W       = 32;
   localparam int REQ_W       = 152;
   localparam int RSP_W       = 96;
   localparam logic [16:0] ONE_Q16   = 17'h10000;
   localparam logic [30:0] STR_MAX   = 31'((64'd1 << (TOTAL_WIDTH - 1)) - 64'd1);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] REG_PASS_MAX  = 3'd0;
   localparam logic [2:0] REG_TOLERANCE = 3'd1;
   localparam logic [2:0] REG_MAX_STEPS = 3'd2;
   localparam logic [2:0] REG_FINAL_DMG = 3'd3;
   localparam logic [2:0] REG_MODULUS   = 3'd4;
   localparam logic [2:0] REG_INV_RATIO = 3'd5;

   typedef struct packed {
      logic [7:0]  step_count_out;
      logic [16:0] damage_out;
      logic [30:0] strength_out;
      logic        was_damaged;
      logic [31:0] damaged_total;
      logic        calc;
      logic [16:0] one_minus_d;
      logic [30:0] eps_u;
      logic [31:0] tangent;
   } isrs_entry_type;
endpackage
`default_nettype wire

// ===== hw/rtl/isrs_front.sv =====
// Front end: configuration registers, damage gate, count and damage update, point counter.
// Depends on isrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isrs_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_we,
   input  wire  [2:0]               csr_index,
   input  wire  [30:0]              csr_wdata,
   input  wire                      accept,
   input  wire  [isrs_pkg::REQ_W-1:0] req_tdata,
   output isrs_pkg::isrs_entry_type entry,
   output logic [30:0]              modulus
);
   import isrs_pkg::*;

   logic [30:0] pass_max_ff, modulus_ff;
   logic [16:0] tol_ff, final_ff, ratio_ff;
   logic [7:0]  max_steps_ff;
   logic [31:0] counter_ff, counter_in;

   logic        first;
   logic signed [31:0] stress;
   logic [7:0]  count, count_inc;
   logic [16:0] dam, tol, ratio, om0, om1, dam_new;
   logic [30:0] sc, eps;
   logic [31:0] tan, base;
   logic [47:0] thr;
   logic signed [48:0] lhs, rhs;
   logic [33:0] om_prod;
   logic        hit, at_lim;

   always_comb begin
      first  = req_tdata[0];
      stress = req_tdata[32:1];
      count  = req_tdata[40:33];
      dam    = req_tdata[57:41];
      sc     = req_tdata[88:58];
      eps    = req_tdata[119:89];
      tan    = req_tdata[151:120];
      tol    = (tol_ff > ONE_Q16) ? ONE_Q16 : tol_ff;
      ratio  = (ratio_ff > ONE_Q16) ? ONE_Q16 : ratio_ff;
      thr    = 48'(ONE_Q16 - tol) * 48'(pass_max_ff);
      lhs    = {stress[31], stress, 16'd0};
      rhs    = {1'b0, thr};
      hit    = (pass_max_ff[30:FRAC_BITS] != '0) && (lhs >= rhs) && (count < max_steps_ff);
      count_inc = count + 8'd1;
      at_lim = (count_inc == max_steps_ff);
      om0    = ONE_Q16 - ((dam > ONE_Q16) ? ONE_Q16 : dam);
      om_prod = 34'(om0) * 34'(ratio);
      om1    = om_prod[32:16];
      dam_new = ONE_Q16 - om1;
      base   = first ? 32'd0 : counter_ff;
      counter_in = (hit && base != 32'hFFFF_FFFF) ? base + 32'd1 : base;

      entry.step_count_out = hit ? count_inc : count;
      entry.damage_out     = hit ? (at_lim ? final_ff : dam_new) : dam;
      entry.strength_out   = sc;
      entry.was_damaged    = hit;
      entry.damaged_total  = counter_in;
      entry.calc           = hit && !at_lim;
      entry.one_minus_d    = om1;
      entry.eps_u          = eps;
      entry.tangent        = tan;
      modulus              = modulus_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_max_ff  <= '0;
         tol_ff       <= 17'd655;
         max_steps_ff <= 8'd10;
         final_ff     <= ONE_Q16;
         modulus_ff   <= 31'd65536;
         ratio_ff     <= 17'd32768;
         counter_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PASS_MAX:  pass_max_ff  <= csr_wdata;
               REG_TOLERANCE: tol_ff       <= csr_wdata[16:0];
               REG_MAX_STEPS: max_steps_ff <= csr_wdata[7:0];
               REG_FINAL_DMG: final_ff     <= csr_wdata[16:0];
               REG_MODULUS:   modulus_ff   <= csr_wdata;
               REG_INV_RATIO: ratio_ff     <= csr_wdata[16:0];
               default: ;
            endcase
         end
         if (accept) counter_ff <= counter_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/isrs_queue.sv =====
// Two-entry queue between front end and back end.
// Depends on isrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isrs_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire isrs_pkg::isrs_entry_type wr_entry,
   output logic                     full,
   input  wire                      pop,
   output logic                     not_empty,
   output isrs_pkg::isrs_entry_type rd_entry
);
   import isrs_pkg::*;

   isrs_entry_type slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;

   assign full      = (cnt_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != 2'd0);
   assign rd_entry  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wr_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/isrs_div.sv =====
// Radix-2 restoring divider for the strength quotient, one quotient bit per cycle.
// Depends on isrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isrs_div (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire  [isrs_pkg::NUM_W-1:0] num,
   input  wire  [isrs_pkg::DEN_W-1:0] den,
   output logic                       done,
   output logic                       sat,
   output logic [isrs_pkg::QBITS-1:0] quot
);
   import isrs_pkg::*;
   localparam int CW = $clog2(QBITS + 1);

   logic             busy_ff, done_ff, sat_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [QBITS-1:0] low_ff, q_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, low_ff[QBITS-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign done  = done_ff;
   assign sat   = sat_ff;
   assign quot  = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sat_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (DEN_W'(num[NUM_W-1:QBITS]) >= den) begin
               sat_ff  <= 1'b1;
               done_ff <= 1'b1;
            end else begin
               sat_ff  <= 1'b0;
               busy_ff <= 1'b1;
               cnt_ff  <= CW'(QBITS);
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DEN_W'(num[NUM_W-1:QBITS]);
         low_ff <= num[QBITS-1:0];
         den_ff <= den;
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         low_ff <= {low_ff[QBITS-2:0], 1'b0};
         q_ff   <= {q_ff[QBITS-2:0], fits};
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/isrs_back.sv =====
// Back end: strength update sequencer with multiply steps, divider and output register.
// Depends on isrs_pkg, isrs_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "iterative_stiffness_reduction_step_top_defines.svh"
module isrs_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        q_valid,
   input  wire isrs_pkg::isrs_entry_type q_entry,
   output logic                       q_pop,
   input  wire  [30:0]                modulus,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [isrs_pkg::RSP_W-1:0] rsp_tdata
);
   import isrs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL_A, S_MUL_N, S_DIV, S_MUL_LO, S_MUL_HI, S_SUM, S_OUT
   } state_type;

   state_type      state_ff;
   isrs_entry_type hold_ff;
   logic [30:0]    a_ff, result_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic           div_start_ff;
   logic [QBITS-1:0] mag_ff;
   logic [54:0]    plo_ff;
   logic [53:0]    phi_ff;
   logic           out_valid_ff;
   isrs_entry_type out_ff;

   logic           out_free, div_done, div_sat;
   logic [QBITS-1:0] div_q;
   logic [47:0]    a_prod;
   logic signed [63:0] n_prod;
   logic signed [32:0] den_s;
   logic [78:0]    total;
   logic [62:0]    p_shift;

   assign out_free = !out_valid_ff || rsp_tready;
   assign q_pop    = (state_ff == S_IDLE) && q_valid && out_free;

   always_comb begin
      a_prod  = 48'(hold_ff.one_minus_d) * 48'(modulus);
      n_prod  = $signed({1'b0, a_ff}) * $signed(hold_ff.tangent);
      den_s   = $signed({2'b00, a_ff}) + $signed({hold_ff.tangent[31], hold_ff.tangent});
      total   = {phi_ff, 24'd0} + 79'(plo_ff);
      p_shift = total[78:FRAC_BITS];
   end

   isrs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .sat   (div_sat),
      .quot  (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  if (q_entry.calc) begin
                     hold_ff  <= q_entry;
                     state_ff <= S_MUL_A;
                  end else begin
                     out_ff       <= q_entry;
                     out_valid_ff <= 1'b1;
                  end
               end
            end
            S_MUL_A: begin
               a_ff     <= a_prod[46:16];
               state_ff <= S_MUL_N;
            end
            S_MUL_N: begin
               num_ff <= n_prod[63] ? 63'(-n_prod) : n_prod[62:0];
               den_ff <= den_s[32] ? DEN_W'(-den_s) : den_s[31:0];
               if (den_s == '0) begin
                  result_ff <= STR_MAX;
                  state_ff  <= S_OUT;
               end else if (n_prod == '0 || (n_prod[63] != den_s[32])) begin
                  result_ff <= '0;
                  state_ff  <= S_OUT;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  if (div_sat) begin
                     result_ff <= (hold_ff.eps_u != '0) ? STR_MAX : '0;
                     state_ff  <= S_OUT;
                  end else begin
                     mag_ff   <= div_q;
                     state_ff <= S_MUL_LO;
                  end
               end
            end
            S_MUL_LO: begin
               plo_ff   <= 55'(mag_ff[23:0]) * 55'(hold_ff.eps_u);
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               phi_ff   <= 54'(mag_ff[QBITS-1:24]) * 54'(hold_ff.eps_u);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               result_ff <= (p_shift > 63'(STR_MAX)) ? STR_MAX : p_shift[30:0];
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  out_ff              <= hold_ff;
                  out_ff.strength_out <= result_ff;
                  out_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.damaged_total, out_ff.was_damaged, out_ff.strength_out,
                        out_ff.damage_out, out_ff.step_count_out};

   `ISRS_ASSERT_NOW(a_done_in_div, div_done, state_ff == S_DIV, "divider done outside divide state")
   `ISRS_ASSERT_NEXT(a_calc_starts, q_pop && q_entry.calc, state_ff == S_MUL_A, "calc entry lost")
   `ISRS_ASSERT_NEXT(a_out_loads, state_ff == S_OUT && out_free, out_valid_ff, "result not loaded")
endmodule
`default_nettype wire

// ===== hw/rtl/iterative_stiffness_reduction_step_top.sv =====
// Top level of the stiffness reduction step: front end, queue and back end.
// Depends on isrs_pkg, isrs_front, isrs_queue and isrs_back.
//
// One item per integration point, one result per item, in order. An item that is not
// reduced, or that reaches the reduction limit, passes through the queue into the output
// register; an item that needs a new strength goes through the multiply steps of the
// back-end sequencer and the 47-step radix-2 divider (the divider is skipped when the
// signs or a zero divisor settle the strength, and the later multiply steps when the
// quotient overflows). The back end takes the next item only once the result register is
// free. A two-entry queue lets the front end accept items while the back end works.
`timescale 1ns / 1ps
`default_nettype none
module iterative_stiffness_reduction_step_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_we,
   input  wire  [2:0]   csr_index,
   input  wire  [30:0]  csr_wdata,
   input  wire          req_tvalid,
   output logic         req_tready,
   // first_of_pass, equiv_stress, step_count, damage_in, strength_in,
   // failure_strain, softening_tangent
   input  wire  [isrs_pkg::REQ_W-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // step_count_out, damage_out, strength_out, was_damaged, damaged_total, zero fill
   output logic [isrs_pkg::RSP_W-1:0] rsp_tdata
);
   import isrs_pkg::*;

   isrs_entry_type fe_entry, q_entry;
   logic [30:0] modulus;
   logic q_full, q_valid, q_pop, accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   isrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_tdata (req_tdata),
      .entry     (fe_entry),
      .modulus   (modulus)
   );

   isrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .wr_entry  (fe_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .rd_entry  (q_entry)
   );

   isrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .modulus    (modulus),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire

// ===== bench/iterative_stiffness_reduction_step_top_test.sv =====
// Self-checking bench for iterative_stiffness_reduction_step_top: streams integration points,
// predicts each result in a scoreboard class and compares it field by field.
// Depends on isrs_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none

typedef struct packed {
   logic [31:0] softening_tangent;
   logic [30:0] failure_strain;
   logic [30:0] strength_in;
   logic [16:0] damage_in;
   logic [7:0]  step_count;
   logic [31:0] equiv_stress;
   logic        first_of_pass;
} point_in_t;

typedef struct packed {
   logic [6:0]  fill;
   logic [31:0] damaged_total;
   logic        was_damaged;
   logic [30:0] strength_out;
   logic [16:0] damage_out;
   logic [7:0]  step_count_out;
} point_out_t;

class damage_scoreboard;
   logic [30:0] pass_max;
   logic [16:0] tolerance;
   logic [7:0]  max_steps;
   logic [16:0] final_dmg;
   logic [30:0] modulus;
   logic [16:0] inv_ratio;
   logic [31:0] damaged_count;
   point_out_t  expected_q[$];
   int          errors;

   function new();
      pass_max = 0; tolerance = 655; max_steps = 10; final_dmg = 17'h10000;
      modulus = 31'h10000; inv_ratio = 17'h08000; damaged_count = 0; errors = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [30:0] val);
      case (idx)
         isrs_pkg::REG_PASS_MAX:  pass_max  = val;
         isrs_pkg::REG_TOLERANCE: tolerance = val[16:0];
         isrs_pkg::REG_MAX_STEPS: max_steps = val[7:0];
         isrs_pkg::REG_FINAL_DMG: final_dmg = val[16:0];
         isrs_pkg::REG_MODULUS:   modulus   = val;
         isrs_pkg::REG_INV_RATIO: inv_ratio = val[16:0];
         default: ;
      endcase
   endfunction

   function longint stress_threshold();
      longint unsigned tol;
      tol = (tolerance > 65536) ? 65536 : tolerance;
      return longint'((65536 - tol) * longint'(pass_max));
   endfunction

   function logic [30:0] new_strength(longint unsigned om, longint d, longint unsigned eps);
      longint a, den, h;
      longint unsigned p;
      a = longint'((om * modulus) >> 16);
      den = a + d;
      if (den == 0) return isrs_pkg::STR_MAX;
      h = (a * d) / den;
      if (h <= 0 || eps == 0) return 0;
      if (longint'(h) > 64'h7FFF_FFFF_FFFF_FFFF / eps) return isrs_pkg::STR_MAX;
      p = (longint'(h) * eps) >> isrs_pkg::FRAC_BITS;
      return (p > isrs_pkg::STR_MAX) ? isrs_pkg::STR_MAX : p[30:0];
   endfunction

   function void note_input(point_in_t pt);
      point_out_t r;
      longint unsigned om, ratio;
      r = '0;
      r.step_count_out = pt.step_count;
      r.damage_out = pt.damage_in;
      r.strength_out = pt.strength_in;
      if (pt.first_of_pass) damaged_count = 0;
      if (pass_max >= 31'h10000 &&
          longint'($signed(pt.equiv_stress)) * 65536 >= stress_threshold() &&
          pt.step_count < max_steps) begin
         r.was_damaged = 1;
         r.step_count_out = 8'(pt.step_count + 8'd1);
         if (r.step_count_out == max_steps) begin
            r.damage_out = final_dmg;
         end else begin
            ratio = (inv_ratio > 65536) ? 65536 : inv_ratio;
            om = 65536 - ((pt.damage_in > 65536) ? 65536 : pt.damage_in);
            om = (om * ratio) >> 16;
            r.damage_out = 17'(65536 - om);
            r.strength_out = new_strength(om, longint'($signed(pt.softening_tangent)),
                                          pt.failure_strain);
         end
         if (damaged_count != 32'hFFFF_FFFF) damaged_count++;
      end
      r.damaged_total = damaged_count;
      expected_q.push_back(r);
   endfunction

   function void check_result(point_out_t got);
      point_out_t e;
      if (expected_q.size() == 0) begin
         $error("unexpected result transfer %h", got);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (got.step_count_out !== e.step_count_out) begin
         $error("step_count_out expected %0d got %0d", e.step_count_out, got.step_count_out);
         errors++;
      end
      if (got.damage_out !== e.damage_out) begin
         $error("damage_out expected %0d got %0d", e.damage_out, got.damage_out);
         errors++;
      end
      if (got.strength_out !== e.strength_out) begin
         $error("strength_out expected %0d got %0d", e.strength_out, got.strength_out);
         errors++;
      end
      if (got.was_damaged !== e.was_damaged) begin
         $error("was_damaged expected %0d got %0d", e.was_damaged, got.was_damaged);
         errors++;
      end
      if (got.damaged_total !== e.damaged_total) begin
         $error("damaged_total expected %0d got %0d", e.damaged_total, got.damaged_total);
         errors++;
      end
   endfunction
endclass

module iterative_stiffness_reduction_step_top_test;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [30:0] csr_wdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [isrs_pkg::REQ_W-1:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [isrs_pkg::RSP_W-1:0] rsp_tdata;

   damage_scoreboard sb = new();
   int  results_seen = 0;
   bit  quiet = 0;
   longint cycles = 0;

   iterative_stiffness_reduction_step_top dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off to back the block up
   initial begin : receiver
      int stall_left;
      bit long_done;
      stall_left = 0;
      long_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_result(point_out_t'(rsp_tdata));
            results_seen++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else if (!long_done && results_seen == 40) begin
            long_done = 1;
            stall_left = 600;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [30:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic send_point(point_in_t pt);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= pt;
      do @(posedge clock); while (!req_tready);
      sb.note_input(pt);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic point_in_t random_point();
      point_in_t pt;
      longint thr, s, om, a;
      pt.first_of_pass = ($urandom_range(0, 49) == 0);
      pt.step_count = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                      : 8'($urandom_range(0, (sb.max_steps > 0) ? sb.max_steps : 0));
      pt.damage_in = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      pt.strength_in = 31'($urandom);
      pt.failure_strain = ($urandom_range(0, 1)) ? 31'($urandom_range(0, 32'h4_0000))
                                                 : 31'($urandom);
      pt.softening_tangent = $urandom;
      if ($urandom_range(0, 19) == 0) begin
         om = 65536 - ((pt.damage_in > 65536) ? 65536 : pt.damage_in);
         om = (om * ((sb.inv_ratio > 65536) ? 65536 : sb.inv_ratio)) >> 16;
         a = (om * sb.modulus) >> 16;
         pt.softening_tangent = 32'(-a);
      end
      thr = sb.stress_threshold() >>> 16;
      case ($urandom_range(0, 3))
         0: s = longint'($signed($urandom));
         1: s = thr + $urandom_range(0, 6) - 3;
         default: s = thr + $urandom_range(0, 32'h20000);
      endcase
      if (s > 32'sh7FFF_FFFF) s = 32'sh7FFF_FFFF;
      pt.equiv_stress = 32'(s);
      return pt;
   endfunction

   function automatic point_in_t make_point(bit fp, logic [31:0] st, logic [7:0] cnt,
                                            logic [16:0] dm, logic [31:0] tan);
      point_in_t pt;
      pt.first_of_pass = fp; pt.equiv_stress = st; pt.step_count = cnt;
      pt.damage_in = dm; pt.strength_in = 31'h1234_5678;
      pt.failure_strain = 31'h0002_0000; pt.softening_tangent = tan;
      return pt;
   endfunction

   initial begin : stimulus
      int n;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // gate closed with reset settings, then open
      send_point(make_point(1, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_0000));
      drain();
      write_reg(isrs_pkg::REG_PASS_MAX, 31'h0002_0000);
      write_reg(isrs_pkg::REG_TOLERANCE, 0);
      write_reg(isrs_pkg::REG_MAX_STEPS, 3);
      write_reg(isrs_pkg::REG_FINAL_DMG, 17'h1FFFF);
      write_reg(isrs_pkg::REG_MODULUS, 31'h7FFF_FFFF);
      write_reg(isrs_pkg::REG_INV_RATIO, 17'h1FFFF);
      send_point(make_point(1, 32'h0002_0000, 0, 0, 32'hFFFF_0000));
      send_point(make_point(0, 32'h0001_FFFF, 0, 0, 32'hFFFF_0000));
      send_point(make_point(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF));
      send_point(make_point(0, 32'h7FFF_FFFF, 1, 17'h1FFFF, 32'h8000_0000));
      send_point(make_point(0, 32'h7FFF_FFFF, 2, 17'h08000, 32'h0001_0000));
      send_point(make_point(0, 32'h7FFF_FFFF, 3, 0, 0));
      send_point(make_point(0, 32'h7FFF_FFFF, 8'hFF, 0, 0));
      send_point(make_point(1, 32'h7FFF_FFFF, 0, 17'h10000, 0));
      drain();
      write_reg(isrs_pkg::REG_MODULUS, 0);
      write_reg(isrs_pkg::REG_INV_RATIO, 0);
      write_reg(isrs_pkg::REG_TOLERANCE, 17'h1FFFF);
      send_point(make_point(0, 0, 0, 0, 0));
      send_point(make_point(0, 32'h8000_0000, 1, 17'h04000, 32'h0000_8000));
      drain();
      write_reg(isrs_pkg::REG_MAX_STEPS, 0);
      write_reg(isrs_pkg::REG_PASS_MAX, 31'h7FFF_FFFF);
      send_point(make_point(0, 32'h7FFF_FFFF, 0, 0, 0));
      drain();
      write_reg(isrs_pkg::REG_PASS_MAX, 31'h0000_FFFF);
      write_reg(isrs_pkg::REG_MAX_STEPS, 255);
      send_point(make_point(0, 32'h7FFF_FFFF, 0, 0, 0));
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(isrs_pkg::REG_PASS_MAX, (ph == 7) ? 31'h0000_8000 :
                   (ph == 3) ? 31'h7FFF_FFFF : 31'($urandom_range(32'h1_0000, 32'h40_0000)));
         write_reg(isrs_pkg::REG_TOLERANCE, (ph == 1) ? 17'd0 : (ph == 2) ? 17'h10000 :
                   (ph == 4) ? 17'h1FFFF : 17'($urandom_range(0, 65536)));
         write_reg(isrs_pkg::REG_MAX_STEPS, (ph == 1) ? 8'd1 : (ph == 2) ? 8'd255 :
                   (ph == 5) ? 8'd0 : 8'($urandom_range(2, 20)));
         write_reg(isrs_pkg::REG_FINAL_DMG, (ph == 4) ? 17'h1FFFF : 17'($urandom_range(0, 65536)));
         write_reg(isrs_pkg::REG_MODULUS, (ph == 2) ? 31'h7FFF_FFFF : (ph == 6) ? 31'd0 :
                   31'($urandom_range(1, 32'h100_0000)));
         write_reg(isrs_pkg::REG_INV_RATIO, (ph == 3) ? 17'd1 : (ph == 6) ? 17'h1FFFF :
                   17'($urandom_range(1, 65536)));
         n = (ph == 7) ? 100 : 235;
         for (int i = 0; i < n; i++) begin
            if (ph == 6 && i == 120) quiet = 1;
            send_point(random_point());
         end
         drain();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/isrs_pkg.sv
hw/rtl/isrs_front.sv
hw/rtl/isrs_queue.sv
hw/rtl/isrs_div.sv
hw/rtl/isrs_back.sv
hw/rtl/iterative_stiffness_reduction_step_top.sv
bench/iterative_stiffness_reduction_step_top_test.sv
